/* hdl/tlbpa_pkg.sv */
// ----------------------------------------------------------------------------
// tlbpa_pkg
// Shared constants, codes and controller/datapath handshake structs for the
// two-level bitmap page allocator.
// ----------------------------------------------------------------------------
package tlbpa_pkg;

    // Default geometry
    localparam int MAX_REGIONS_DEF      = 32;
    localparam int WORDS_PER_REGION_DEF = 32;

    // Fixed field widths
    localparam int OP_W     = 1;
    localparam int PAGE_W   = 15;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 6;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int WI_W     = PAGE_W - BIT_W;

    localparam logic [CFG_W-1:0]  REGIONS_RESET = 6'd4;
    localparam logic [WORD_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;

    // Address width for a store of n entries (at least one bit)
    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic alloc_start;
        logic scan_issue;
        logic alloc_commit;
        logic alloc_fail;
        logic free_read;
        logic free_commit;
        logic load_out;
    } tlbpa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic op_free;
        logic any_region;
        logic hit;
        logic pending;
        logic scan_done;
        logic out_free;
    } tlbpa_sts_t;

endpackage

/* hdl/tlbpa_req_if.sv */
// ----------------------------------------------------------------------------
// tlbpa_req_if
// Request channel: allocate or free one page.
// ----------------------------------------------------------------------------
interface tlbpa_req_if;

    logic                           valid;
    logic                           ready;
    logic [tlbpa_pkg::OP_W-1:0]     op;
    logic [tlbpa_pkg::PAGE_W-1:0]   page_number;

    modport source (output valid, output op, output page_number, input ready);
    modport sink   (input valid, input op, input page_number, output ready);

endinterface

/* hdl/tlbpa_rsp_if.sv */
// ----------------------------------------------------------------------------
// tlbpa_rsp_if
// Response channel: granted page and completion status.
// ----------------------------------------------------------------------------
interface tlbpa_rsp_if;

    logic                             valid;
    logic                             ready;
    logic [tlbpa_pkg::PAGE_W-1:0]     granted_page;
    logic [tlbpa_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output granted_page, output status, input ready);
    modport sink   (input valid, input granted_page, input status, output ready);

endinterface

/* hdl/tlbpa_ram.sv */
// ----------------------------------------------------------------------------
// tlbpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Contents are undefined after reset.
// ----------------------------------------------------------------------------
module tlbpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [tlbpa_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [tlbpa_pkg::addr_w(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tlbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// tlbpa_ctrl
// Sequencer for the page allocator: bitmap clearing pass after reset, then
// one request at a time (region pick, word scan, bitmap update, response).
// ----------------------------------------------------------------------------
module tlbpa_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output tlbpa_pkg::tlbpa_cmd_t   cmd,
    input  tlbpa_pkg::tlbpa_sts_t   sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_FREE_CHK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                priority if (sts.op_free)
                begin
                    cmd.free_read = 1'b1;
                    state_next    = S_FREE_CHK;
                end
                else if (sts.any_region)
                begin
                    cmd.alloc_start = 1'b1;
                    state_next      = S_SCAN;
                end
                else
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_RESP;
                end
            end
            S_SCAN:
            begin
                // word data arrives in the cycle after its address is issued
                priority if (sts.hit)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_RESP;
                end
                else if (!sts.scan_done)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else if (!sts.pending)
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    // last word read still in flight
                    state_next = S_SCAN;
                end
            end
            S_FREE_CHK:
            begin
                cmd.free_commit = 1'b1;
                state_next      = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/tlbpa_dp.sv */
// ----------------------------------------------------------------------------
// tlbpa_dp
// Allocator datapath: page bitmap RAM, per-region free counts and full bits,
// region priority pick, lowest-clear-bit search, result and output registers.
// ----------------------------------------------------------------------------
module tlbpa_dp #(
    parameter int MAX_REGIONS      = tlbpa_pkg::MAX_REGIONS_DEF,
    parameter int WORDS_PER_REGION = tlbpa_pkg::WORDS_PER_REGION_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tlbpa_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [tlbpa_pkg::OP_W-1:0]          in_op,
    input  logic [tlbpa_pkg::PAGE_W-1:0]        in_page_number,
    input  tlbpa_pkg::tlbpa_cmd_t               cmd,
    output tlbpa_pkg::tlbpa_sts_t               sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tlbpa_pkg::PAGE_W-1:0]        out_granted_page,
    output logic [tlbpa_pkg::STATUS_W-1:0]      out_status
);

    localparam int OP_W     = tlbpa_pkg::OP_W;
    localparam int PAGE_W   = tlbpa_pkg::PAGE_W;
    localparam int STATUS_W = tlbpa_pkg::STATUS_W;
    localparam int CFG_W    = tlbpa_pkg::CFG_W;
    localparam int WORD_W   = tlbpa_pkg::WORD_W;
    localparam int BIT_W    = tlbpa_pkg::BIT_W;
    localparam int WI_W     = tlbpa_pkg::WI_W;

    localparam int TOTAL_WORDS = MAX_REGIONS * WORDS_PER_REGION;
    localparam int PAGES       = WORDS_PER_REGION * WORD_W;
    localparam int AW          = tlbpa_pkg::addr_w(TOTAL_WORDS);
    localparam int RW          = tlbpa_pkg::addr_w(MAX_REGIONS);
    localparam int KW          = $clog2(WORDS_PER_REGION + 1);
    localparam int CNT_W       = $clog2(PAGES + 1);

    // region = word index / WORDS_PER_REGION via rounded-up reciprocal
    localparam int RECIP_SH = WI_W + 7;
    localparam int RECIP_MW = RECIP_SH + 1;
    localparam int PROD_W   = WI_W + RECIP_MW;
    localparam logic [RECIP_MW-1:0] RECIP_M =
        RECIP_MW'(((1 << RECIP_SH) + WORDS_PER_REGION - 1) / WORDS_PER_REGION);

    // configuration
    logic [CFG_W-1:0]    regions_reg;

    // request capture
    logic [OP_W-1:0]     op_reg;
    logic [PAGE_W-1:0]   page_reg;

    // scan and access bookkeeping
    logic [AW-1:0]       clear_addr_reg;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [KW-1:0]       kcnt_reg;
    logic                pending_reg;
    logic [RW-1:0]       region_reg;
    logic                in_range_reg;

    // region state
    logic [CNT_W-1:0]        count_reg [MAX_REGIONS];
    logic [MAX_REGIONS-1:0]  full_reg;

    // result and output registers
    logic [PAGE_W-1:0]   res_page_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // combinational
    logic [CFG_W-1:0]    limit;
    logic                pick_found;
    logic [RW-1:0]       pick_idx;
    logic [WI_W-1:0]     wi;
    logic [PROD_W-1:0]   recip_prod;
    logic [RW-1:0]       free_region;
    logic                free_in_range;
    logic [WORD_W-1:0]   rd_data;
    logic [BIT_W-1:0]    lc_bit;
    logic                free_ok;
    logic [CNT_W-1:0]    cur_count;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   bit_mask;

    // lowest in-use region with free pages
    assign limit = (regions_reg > CFG_W'(MAX_REGIONS)) ? CFG_W'(MAX_REGIONS) : regions_reg;

    always_comb
    begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int r = MAX_REGIONS - 1; r >= 0; r--)
        begin
            if (!full_reg[r] && (CFG_W'(r) < limit))
            begin
                pick_found = 1'b1;
                pick_idx   = RW'(r);
            end
        end
    end

    // free address decode
    assign wi            = page_reg[PAGE_W-1:BIT_W];
    assign recip_prod    = PROD_W'(wi) * PROD_W'(RECIP_M);
    assign free_region   = RW'(recip_prod >> RECIP_SH);
    assign free_in_range = (32'(wi) < 32'(TOTAL_WORDS));

    // lowest clear bit of the word just read
    always_comb
    begin
        lc_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!rd_data[i])
            begin
                lc_bit = BIT_W'(i);
            end
        end
    end

    assign free_ok   = in_range_reg && rd_data[page_reg[BIT_W-1:0]];
    assign cur_count = count_reg[region_reg];
    assign bit_mask  = WORD_W'(1) << (cmd.alloc_commit ? lc_bit : page_reg[BIT_W-1:0]);

    // bitmap RAM ports
    assign ram_raddr = cmd.free_read ? AW'(wi) : addr_reg;
    assign ram_we    = cmd.clr_step || cmd.alloc_commit || (cmd.free_commit && free_ok);
    assign ram_waddr = cmd.clr_step ? clear_addr_reg : rd_addr_reg;

    always_comb
    begin
        priority if (cmd.clr_step)
        begin
            ram_wdata = (32'(clear_addr_reg) < 32'(WORDS_PER_REGION))
                        ? tlbpa_pkg::ALL_ONES : '0;
        end
        else if (cmd.alloc_commit)
        begin
            ram_wdata = rd_data | bit_mask;
        end
        else
        begin
            ram_wdata = rd_data & ~bit_mask;
        end
    end

    tlbpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // status to controller
    assign sts.clr_last   = (clear_addr_reg == AW'(TOTAL_WORDS - 1));
    assign sts.op_free    = (op_reg == tlbpa_pkg::OP_FREE);
    assign sts.any_region = pick_found;
    assign sts.hit        = pending_reg && (rd_data != tlbpa_pkg::ALL_ONES);
    assign sts.pending    = pending_reg;
    assign sts.scan_done  = (kcnt_reg == KW'(WORDS_PER_REGION));
    assign sts.out_free   = !out_valid_reg || out_ready;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_reg <= tlbpa_pkg::REGIONS_RESET;
        end
        else if (cfg_we)
        begin
            regions_reg <= cfg_wdata;
        end
    end

    // clearing pass address and read-pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clear_addr_reg <= AW'(clear_addr_reg + 1'b1);
            end
            pending_reg <= cmd.scan_issue;
        end
    end

    // request capture, scan address and counters
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            page_reg <= in_page_number;
        end
        if (cmd.alloc_start)
        begin
            region_reg <= pick_idx;
            addr_reg   <= AW'(32'(pick_idx) * WORDS_PER_REGION);
            kcnt_reg   <= '0;
        end
        else if (cmd.scan_issue)
        begin
            rd_addr_reg <= addr_reg;
            addr_reg    <= AW'(addr_reg + 1'b1);
            kcnt_reg    <= KW'(kcnt_reg + 1'b1);
        end
        else if (cmd.free_read)
        begin
            rd_addr_reg  <= AW'(wi);
            region_reg   <= free_region;
            in_range_reg <= free_in_range;
        end
    end

    // region free counts and full bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_REGIONS; r++)
            begin
                count_reg[r] <= (r == 0) ? '0 : CNT_W'(PAGES);
            end
            full_reg <= MAX_REGIONS'(1);
        end
        else if (cmd.alloc_commit)
        begin
            count_reg[region_reg] <= CNT_W'(cur_count - 1'b1);
            if (cur_count == CNT_W'(1))
            begin
                full_reg[region_reg] <= 1'b1;
            end
        end
        else if (cmd.free_commit && free_ok)
        begin
            full_reg[region_reg] <= 1'b0;
            if (cur_count < CNT_W'(PAGES))
            begin
                count_reg[region_reg] <= CNT_W'(cur_count + 1'b1);
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        priority if (cmd.alloc_commit)
        begin
            res_page_reg   <= PAGE_W'({rd_addr_reg, lc_bit});
            res_status_reg <= tlbpa_pkg::ST_OK;
        end
        else if (cmd.alloc_fail)
        begin
            res_page_reg   <= '0;
            res_status_reg <= tlbpa_pkg::ST_NO_MEMORY;
        end
        else if (cmd.free_commit)
        begin
            res_page_reg   <= '0;
            res_status_reg <= free_ok ? tlbpa_pkg::ST_OK : tlbpa_pkg::ST_BAD_FREE;
        end
        else
        begin
            res_page_reg   <= res_page_reg;
            res_status_reg <= res_status_reg;
        end
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_page_reg   <= res_page_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_granted_page = out_page_reg;
    assign out_status       = out_status_reg;

endmodule

/* hdl/two_level_bitmap_page_allocator_core.sv */
// ----------------------------------------------------------------------------
// two_level_bitmap_page_allocator_core
// Physical page allocator over regions of WORDS_PER_REGION*32 pages.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page bitmap RAM, one
// word per cycle, over all MAX_REGIONS*WORDS_PER_REGION words (1024 at the
// defaults), and takes no request until it is done. The user must write
// regions_in_use only while no request is in flight; the block does not
// enforce this. Requests are handled one at a time. An allocation picks the
// lowest non-full region in use by priority encode, then reads the region's
// bitmap words one per cycle through the single read port of the bitmap
// RAM; the grant is the lowest clear bit of the first word not all ones. A
// free reads the page's word and clears its bit if in use; an allocation
// with no non-full region in use fails without a scan. The next request can
// be taken in the cycle after the response is loaded. The response sits in
// an output register, so the next request is taken while it waits to be read.
// ----------------------------------------------------------------------------
module two_level_bitmap_page_allocator_core #(
    parameter int MAX_REGIONS      = tlbpa_pkg::MAX_REGIONS_DEF,
    parameter int WORDS_PER_REGION = tlbpa_pkg::WORDS_PER_REGION_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlbpa_pkg::CFG_W-1:0]   cfg_wdata,
    tlbpa_req_if.sink                     req,
    tlbpa_rsp_if.source                   rsp
);

    tlbpa_pkg::tlbpa_cmd_t cmd;
    tlbpa_pkg::tlbpa_sts_t sts;

    tlbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tlbpa_dp #(
        .MAX_REGIONS      (MAX_REGIONS),
        .WORDS_PER_REGION (WORDS_PER_REGION)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_op            (req.op),
        .in_page_number   (req.page_number),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_granted_page (rsp.granted_page),
        .out_status       (rsp.status)
    );

endmodule

/* tb/tb_two_level_bitmap_page_allocator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_level_bitmap_page_allocator_core
// Self-checking bench for the two-level bitmap page allocator. A shadow copy
// of the page bitmap, per-region free counts and full bits predicts every
// grant and status. Directed allocate/free transactions come first, then
// random phases over several region counts (0, 1, 2, 4, 32, above 32, random).
// Both channels get random gaps. Each phase drains before the next register
// write.
// ----------------------------------------------------------------------------
module tb_two_level_bitmap_page_allocator_core;

    localparam int NUM_REGIONS     = tlbpa_pkg::MAX_REGIONS_DEF;
    localparam int REGION_WORDS    = tlbpa_pkg::WORDS_PER_REGION_DEF;
    localparam int MAP_WORDS       = NUM_REGIONS * REGION_WORDS;
    localparam int REGION_PAGES    = REGION_WORDS * tlbpa_pkg::WORD_W;
    localparam int STALL_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 60;

    typedef struct packed {
        logic [tlbpa_pkg::OP_W-1:0]   op;
        logic [tlbpa_pkg::PAGE_W-1:0] page;
    } page_req_t;

    typedef struct packed {
        logic [tlbpa_pkg::PAGE_W-1:0]   page;
        logic [tlbpa_pkg::STATUS_W-1:0] status;
    } grant_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [tlbpa_pkg::CFG_W-1:0]   cfg_wdata;

    tlbpa_req_if req_bus ();
    tlbpa_rsp_if rsp_bus ();

    two_level_bitmap_page_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Shadow allocator state
    logic [tlbpa_pkg::WORD_W-1:0]   used_map [MAP_WORDS];
    logic [10:0]                    free_cnt [NUM_REGIONS];
    logic [tlbpa_pkg::WORD_W-1:0]   full_mask;
    logic [tlbpa_pkg::CFG_W-1:0]    regions_cfg;

    page_req_t                      req_backlog [$];
    grant_t                         expected_grants [$];
    logic [tlbpa_pkg::PAGE_W-1:0]   granted_pool [$];

    int                  n_queued;
    int                  n_accepted;
    int                  error_count;
    int                  idle_cycles;
    bit                  req_taken;
    bit                  rsp_taken;
    int                  send_gap;
    int                  send_steady;
    int                  recv_stall;
    int                  recv_steady;
    page_req_t           next_req;
    grant_t              pred;
    grant_t              want;

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Lowest free page in the lowest usable region; no_memory if none
    function automatic void predict_alloc(output logic [tlbpa_pkg::PAGE_W-1:0] pg,
                                          output logic [tlbpa_pkg::STATUS_W-1:0] st);
        int  limit;
        int  wi;
        int  b;
        bit  found;
        limit = (regions_cfg > NUM_REGIONS) ? NUM_REGIONS : int'(regions_cfg);
        found = 1'b0;
        pg    = '0;
        st    = tlbpa_pkg::ST_NO_MEMORY;
        for (int r = 0; r < limit && !found; r++)
        begin
            if (free_cnt[r] != 0)
            begin
                for (int k = 0; k < REGION_WORDS && !found; k++)
                begin
                    wi = r * REGION_WORDS + k;
                    if (used_map[wi] != '1)
                    begin
                        b = 0;
                        while (used_map[wi][b])
                            b++;
                        used_map[wi][b] = 1'b1;
                        free_cnt[r] = free_cnt[r] - 1'b1;
                        if (free_cnt[r] == 0)
                            full_mask[r] = 1'b1;
                        pg    = tlbpa_pkg::PAGE_W'(wi * tlbpa_pkg::WORD_W + b);
                        st    = tlbpa_pkg::ST_OK;
                        found = 1'b1;
                    end
                end
            end
        end
    endfunction

    // Release one page; bad_free if it was not in use
    function automatic void predict_free(input logic [tlbpa_pkg::PAGE_W-1:0] pg,
                                         output logic [tlbpa_pkg::STATUS_W-1:0] st);
        int wi;
        int b;
        int r;
        wi = int'(pg) / tlbpa_pkg::WORD_W;
        b  = int'(pg) % tlbpa_pkg::WORD_W;
        if (wi >= MAP_WORDS || !used_map[wi][b])
        begin
            st = tlbpa_pkg::ST_BAD_FREE;
        end
        else
        begin
            r = wi / REGION_WORDS;
            used_map[wi][b] = 1'b0;
            full_mask[r]    = 1'b0;
            if (free_cnt[r] < REGION_PAGES)
                free_cnt[r] = free_cnt[r] + 1'b1;
            st = tlbpa_pkg::ST_OK;
        end
    endfunction

    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
        error_count++;
    endtask

    // Random transaction: allocations, frees of granted pages, frees of
    // reset-used pages in region 0, and the odd free of any page at all
    function automatic page_req_t random_req();
        page_req_t item;
        int        roll;
        int        idx;
        roll      = $urandom_range(0, 99);
        item.page = tlbpa_pkg::PAGE_W'($urandom_range(0, (1 << tlbpa_pkg::PAGE_W) - 1));
        if (roll < 50)
        begin
            item.op = tlbpa_pkg::OP_ALLOC;
        end
        else if (roll < 75 && granted_pool.size() != 0)
        begin
            idx       = $urandom_range(0, granted_pool.size() - 1);
            item.op   = tlbpa_pkg::OP_FREE;
            item.page = granted_pool[idx];
            granted_pool.delete(idx);
        end
        else if (roll < 92)
        begin
            item.op   = tlbpa_pkg::OP_FREE;
            item.page = tlbpa_pkg::PAGE_W'($urandom_range(0, REGION_PAGES - 1));
        end
        else
        begin
            item.op = tlbpa_pkg::OP_FREE;
        end
        return item;
    endfunction

    task automatic push_req(input logic [tlbpa_pkg::OP_W-1:0] op,
                            input logic [tlbpa_pkg::PAGE_W-1:0] pg);
        page_req_t item;
        item.op   = op;
        item.page = pg;
        req_backlog.push_back(item);
        n_queued++;
    endtask

    // Hold until every transaction is accepted and answered
    task automatic drain();
        while (n_accepted != n_queued || expected_grants.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_regions(input logic [tlbpa_pkg::CFG_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we      = 1'b1;
        cfg_wdata   = value;
        regions_cfg = value;
        @(negedge clk);
        cfg_we      = 1'b0;
    endtask

    task automatic random_phase(input logic [tlbpa_pkg::CFG_W-1:0] value, input int count);
        write_regions(value);
        for (int i = 0; i < count; i++)
        begin
            while (req_backlog.size() >= 3)
                @(negedge clk);
            req_backlog.push_back(random_req());
            n_queued++;
        end
    endtask

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
        end
        else if (req_bus.valid && !req_taken)
        begin
            // hold the transaction until it is taken
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            req_bus.valid <= 1'b0;
        end
        else if (req_backlog.size() != 0)
        begin
            next_req = req_backlog.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.op          <= next_req.op;
            req_bus.page_number <= next_req.page;
            if (send_steady > 0)
            begin
                send_steady--;
            end
            else
            begin
                send_gap = idle_len();
                if ($urandom_range(0, 39) == 0)
                    send_steady = $urandom_range(20, 60);
            end
        end
        else
        begin
            req_bus.valid <= 1'b0;
        end
    end

    // Response backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else if (recv_steady > 0)
        begin
            recv_steady--;
            rsp_bus.ready <= 1'b1;
        end
        else if (recv_stall > 0)
        begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_stall = idle_len();
            else if ($urandom_range(0, 59) == 0)
                recv_steady = $urandom_range(30, 80);
        end
    end

    // Monitor: predict on request, check on response, watchdog
    always @(posedge clk)
    begin
        req_taken = rst_n && req_bus.valid && req_bus.ready;
        rsp_taken = rst_n && rsp_bus.valid && rsp_bus.ready;

        if (req_taken)
        begin
            n_accepted++;
            if (req_bus.op == tlbpa_pkg::OP_ALLOC)
            begin
                predict_alloc(pred.page, pred.status);
                if (pred.status == tlbpa_pkg::ST_OK)
                    granted_pool.push_back(pred.page);
            end
            else
            begin
                predict_free(req_bus.page_number, pred.status);
                pred.page = '0;
            end
            expected_grants.push_back(pred);
        end

        if (rsp_taken)
        begin
            if (expected_grants.size() == 0)
            begin
                report_mismatch("unexpected response, status", -1, rsp_bus.status);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (rsp_bus.granted_page !== want.page)
                    report_mismatch("granted_page", want.page, rsp_bus.granted_page);
                if (rsp_bus.status !== want.status)
                    report_mismatch("status", want.status, rsp_bus.status);
            end
        end

        if (rst_n)
        begin
            if (req_taken || rsp_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_bus.valid       = 1'b0;
        req_bus.op          = tlbpa_pkg::OP_ALLOC;
        req_bus.page_number = '0;
        rsp_bus.ready       = 1'b0;
        n_queued            = 0;
        n_accepted          = 0;
        error_count         = 0;
        idle_cycles         = 0;
        send_gap            = 0;
        send_steady         = 0;
        recv_stall          = 0;
        recv_steady         = 0;

        // Reset image: region 0 fully used and full, the rest free
        for (int w = 0; w < MAP_WORDS; w++)
            used_map[w] = (w < REGION_WORDS) ? '1 : '0;
        for (int r = 0; r < NUM_REGIONS; r++)
            free_cnt[r] = (r == 0) ? 11'd0 : 11'(REGION_PAGES);
        full_mask   = 32'h1;
        regions_cfg = tlbpa_pkg::REGIONS_RESET;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset region count, region 0 full at reset
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_ALLOC, '1);
        push_req(tlbpa_pkg::OP_FREE, 15'd1025);
        push_req(tlbpa_pkg::OP_FREE, 15'd1025);
        push_req(tlbpa_pkg::OP_FREE, 15'h7FFF);
        push_req(tlbpa_pkg::OP_FREE, 15'd0);
        push_req(tlbpa_pkg::OP_ALLOC, 15'h5555);
        push_req(tlbpa_pkg::OP_FREE, 15'd1023);
        push_req(tlbpa_pkg::OP_ALLOC, 15'h2AAA);
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_FREE, 15'h5555);
        push_req(tlbpa_pkg::OP_FREE, 15'h2AAA);

        // No region in use: allocations fail, frees still act
        write_regions(6'd0);
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_FREE, 15'd5);
        push_req(tlbpa_pkg::OP_ALLOC, '0);

        // One region: the freed page comes back, then nothing is free
        write_regions(6'd1);
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_FREE, 15'd1024);
        push_req(tlbpa_pkg::OP_ALLOC, '0);

        // Over-range count acts as the maximum
        write_regions(6'd63);
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_ALLOC, '0);
        push_req(tlbpa_pkg::OP_FREE, 15'(31 * REGION_PAGES));

        // Random phases across region counts
        random_phase(6'd2, 170);
        random_phase(6'd1, 170);
        random_phase(6'd32, 150);
        random_phase(6'd0, 80);
        random_phase(6'd63, 130);
        random_phase(6'($urandom_range(1, NUM_REGIONS)), 150);
        random_phase(6'($urandom_range(NUM_REGIONS + 1, 62)), 100);
        random_phase(tlbpa_pkg::REGIONS_RESET, 150);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* two_level_bitmap_page_allocator_core.f */
hdl/tlbpa_pkg.sv
hdl/tlbpa_req_if.sv
hdl/tlbpa_rsp_if.sv
hdl/tlbpa_ram.sv
hdl/tlbpa_ctrl.sv
hdl/tlbpa_dp.sv
hdl/two_level_bitmap_page_allocator_core.sv
tb/tb_two_level_bitmap_page_allocator_core.sv
